@@ design/step_triggered_sample_voice_unit_assert.svh @@
// Assertion macros for the sample voice checker.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef STEP_TRIGGERED_SAMPLE_VOICE_UNIT_ASSERT_SVH
`define STEP_TRIGGERED_SAMPLE_VOICE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define STSV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STSV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/stsv_pkg.sv @@
// ----------------------------------------------------------------------------
// stsv_pkg
// Shared types and constants of the step-triggered sample voice.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stsv_pkg;

  localparam int DEFAULT_SAMPLE_DEPTH = 65536;
  localparam int DEFAULT_STEP_COUNT   = 64;

  localparam int SAMPLE_W  = 16;
  localparam int CNT_W     = 17;
  localparam int STEP_W    = 6;
  localparam int LAST_W    = 7;
  localparam int PATTERN_W = 64;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int GSQ_W     = 31;   // gain squared, at most 2^30

  localparam logic [15:0]       Q_ONE          = 16'h8000;
  localparam logic [15:0]       GAIN_RESET     = 16'd19661;
  localparam logic [15:0]       PAN_RESET      = 16'd16384;
  localparam logic [LAST_W-1:0] LAST_STEP_NONE = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_PATTERN   = 3'd0,
    CFG_GAIN_LEVEL     = 3'd1,
    CFG_PAN_POSITION   = 3'd2,
    CFG_MUTE_ON        = 3'd3,
    CFG_SAMPLE_PRESENT = 3'd4,
    CFG_STEREO_SAMPLE  = 3'd5,
    CFG_START_INDEX    = 3'd6,
    CFG_END_INDEX      = 3'd7
  } cfg_index_e;

  // Request into the scaling pipeline.
  typedef struct packed {
    logic valid;
    logic mute;
  } scale_req_t;

endpackage

`default_nettype wire

@@ design/stsv_mem.sv @@
// ----------------------------------------------------------------------------
// stsv_mem
// Sample memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stsv_mem #(
  parameter int DEPTH = stsv_pkg::DEFAULT_SAMPLE_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [AW-1:0]                 waddr_i,
  input  wire logic [stsv_pkg::SAMPLE_W-1:0] wdata_i,
  input  wire logic                          re_i,
  input  wire logic [AW-1:0]                 raddr_i,
  output logic      [stsv_pkg::SAMPLE_W-1:0] rdata_o
);

  logic [stsv_pkg::SAMPLE_W-1:0] mem_q [DEPTH];
  logic [stsv_pkg::SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/stsv_scale.sv @@
// ----------------------------------------------------------------------------
// stsv_scale
// Three-stage scaling pipeline: |s| * w, times gain squared, then round
// half away from zero by 2^44 (the factor 2 folded in), saturate, mute.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stsv_scale (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire stsv_pkg::scale_req_t              req_i,
  input  wire logic signed [stsv_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic        [15:0]                weight_i,
  input  wire logic        [stsv_pkg::GSQ_W-1:0] gain_sq_i,
  output logic                                   valid_o,
  output logic signed      [stsv_pkg::SAMPLE_W-1:0] result_o
);

  localparam logic [62:0] ROUND_HALF = 63'd1 << 43;

  logic        v1_q, v2_q, v3_q;
  logic        neg1_q, neg2_q;
  logic        mute1_q, mute2_q;
  logic [15:0] mag;
  logic [31:0] t_d, t_q;
  logic [62:0] p_d, p_q;
  logic [62:0] sum;
  logic [18:0] r;
  logic [15:0] r_sat;
  logic signed [stsv_pkg::SAMPLE_W-1:0] res_d, res_q;

  // -32768 maps to 0x8000, read as unsigned
  assign mag = sample_i[15] ? 16'(-sample_i) : 16'(sample_i);
  assign t_d = {16'd0, mag} * {16'd0, weight_i};
  assign p_d = {31'd0, t_q} * {32'd0, gain_sq_i};

  assign sum = p_q + ROUND_HALF;
  assign r   = sum[62:44];

  always_comb begin
    if (neg2_q) begin
      r_sat = (r > 19'd32768) ? 16'h8000 : r[15:0];
    end else begin
      r_sat = (r > 19'd32767) ? 16'h7fff : r[15:0];
    end
    if (mute2_q) begin
      res_d = '0;
    end else if (neg2_q) begin
      res_d = signed'(16'(-r_sat));
    end else begin
      res_d = signed'(r_sat);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    neg1_q  <= sample_i[15];
    mute1_q <= req_i.mute;
    p_q     <= p_d;
    neg2_q  <= neg1_q;
    mute2_q <= mute1_q;
    res_q   <= res_d;
  end

  assign valid_o  = v3_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

@@ design/step_triggered_sample_voice_unit.sv @@
// ----------------------------------------------------------------------------
// step_triggered_sample_voice_unit
// Drum machine sample voice: step trigger, sample playback, gain/pan scaling.
// ----------------------------------------------------------------------------
// Channel  | Dir | Handshake                | Payload
// in       | in  | in_valid_i / in_ready_o  | func, step_number, load_address,
//          |     |                          | load_sample
// out      | out | out_valid_o / out_ready_i| left_out, right_out, playing
// cfg      | in  | cfg_we_i (no wait)       | cfg_index_i, cfg_wdata_i
//
// Write transactions and idle ticks go straight to the emit state. Mono and
// stereo ticks pass through the memory read per sample and the 3-stage scaling
// pipeline shared by both channels; one transaction is in work at a time.
// The output register lets a new transaction start while a result waits.
// Reset is asynchronous; sample memory is not cleared.
// SAMPLE_DEPTH must be a power of two (indexes wrap on the low bits).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module step_triggered_sample_voice_unit #(
  parameter int SAMPLE_DEPTH = stsv_pkg::DEFAULT_SAMPLE_DEPTH,
  parameter int STEP_COUNT   = stsv_pkg::DEFAULT_STEP_COUNT
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [stsv_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [stsv_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 func_i,
  input  wire logic [stsv_pkg::STEP_W-1:0]          step_number_i,
  input  wire logic [15:0]                          load_address_i,
  input  wire logic signed [stsv_pkg::SAMPLE_W-1:0] load_sample_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [stsv_pkg::SAMPLE_W-1:0]      left_out_o,
  output logic signed [stsv_pkg::SAMPLE_W-1:0]      right_out_o,
  output logic                                      playing_o
);

  localparam int AddrW = $clog2(SAMPLE_DEPTH);
  localparam int CntW  = stsv_pkg::CNT_W;
  localparam int SW    = stsv_pkg::SAMPLE_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RD_L, S_RD_R, S_GET_R, S_SCALE_L, S_SCALE_R, S_WAIT, S_EMIT
  } state_e;

  // Configuration registers
  logic [stsv_pkg::PATTERN_W-1:0] pattern_q;
  logic [15:0]     gain_q, pan_q, start_q;
  logic            mute_q, present_q, stereo_q;
  logic [CntW-1:0] end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      gain_q    <= stsv_pkg::GAIN_RESET;
      pan_q     <= stsv_pkg::PAN_RESET;
      mute_q    <= 1'b0;
      present_q <= 1'b0;
      stereo_q  <= 1'b0;
      start_q   <= '0;
      end_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (stsv_pkg::cfg_index_e'(cfg_index_i))
        stsv_pkg::CFG_STEP_PATTERN:   pattern_q <= cfg_wdata_i;
        stsv_pkg::CFG_GAIN_LEVEL:     gain_q    <= cfg_wdata_i[15:0];
        stsv_pkg::CFG_PAN_POSITION:   pan_q     <= cfg_wdata_i[15:0];
        stsv_pkg::CFG_MUTE_ON:        mute_q    <= cfg_wdata_i[0];
        stsv_pkg::CFG_SAMPLE_PRESENT: present_q <= cfg_wdata_i[0];
        stsv_pkg::CFG_STEREO_SAMPLE:  stereo_q  <= cfg_wdata_i[0];
        stsv_pkg::CFG_START_INDEX:    start_q   <= cfg_wdata_i[15:0];
        stsv_pkg::CFG_END_INDEX:      end_q     <= cfg_wdata_i[CntW-1:0];
      endcase
    end
  end

  // Saturated gain and pan weights
  logic [15:0] gain_sat, pan_sat, w_left, w_right;
  assign gain_sat = (gain_q > stsv_pkg::Q_ONE) ? stsv_pkg::Q_ONE : gain_q;
  assign pan_sat  = (pan_q > stsv_pkg::Q_ONE) ? stsv_pkg::Q_ONE : pan_q;
  assign w_left   = stsv_pkg::Q_ONE - pan_sat;
  assign w_right  = pan_sat;

  // Sequencer state
  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [stsv_pkg::LAST_W-1:0] last_q, last_d;
  logic            fin_q, fin_d;
  logic [stsv_pkg::GSQ_W-1:0] gsq_q, gsq_d;
  logic signed [SW-1:0] sl_q, sl_d, sr_q, sr_d;
  logic            got_l_q, got_l_d;
  logic signed [SW-1:0] res_l_q, res_l_d, res_r_q, res_r_d;
  logic            res_p_q, res_p_d;
  logic            out_v_q, out_v_d;
  logic signed [SW-1:0] out_l_q, out_l_d, out_r_q, out_r_d;
  logic            out_p_q, out_p_d;

  // Memory and scaler hookup
  logic             mem_we, mem_re;
  logic [SW-1:0]    mem_rdata;
  logic [31:0]      gsq_full;
  stsv_pkg::scale_req_t scale_req;
  logic signed [SW-1:0] scale_sample;
  logic [15:0]      scale_weight;
  logic             scale_valid;
  logic signed [SW-1:0] scale_result;

  logic step_new, step_hit;

  assign in_ready_o = (state_q == S_IDLE);
  assign mem_we     = in_valid_i && in_ready_o && func_i;
  assign gsq_full   = {16'd0, gain_sat} * {16'd0, gain_sat};

  assign step_new = ({1'b0, step_number_i} != last_q);
  assign step_hit = step_new && ({1'b0, step_number_i} < stsv_pkg::LAST_W'(STEP_COUNT))
                    && pattern_q[step_number_i] && present_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    last_d       = last_q;
    fin_d        = fin_q;
    gsq_d        = gsq_q;
    sl_d         = sl_q;
    sr_d         = sr_q;
    got_l_d      = got_l_q;
    res_l_d      = res_l_q;
    res_r_d      = res_r_q;
    res_p_d      = res_p_q;
    out_v_d      = out_v_q;
    out_l_d      = out_l_q;
    out_r_d      = out_r_q;
    out_p_d      = out_p_q;
    mem_re       = 1'b0;
    scale_req    = '{valid: 1'b0, mute: mute_q};
    scale_sample = sl_q;
    scale_weight = w_left;

    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_l_d = '0;
          res_r_d = '0;
          if (func_i) begin
            res_p_d = !fin_q;
            state_d = S_EMIT;
          end else begin
            if (step_new) begin
              last_d = {1'b0, step_number_i};
            end
            if (step_hit) begin
              fin_d = 1'b0;
              cnt_d = CntW'(start_q);
            end
            if (fin_q && !step_hit) begin
              res_p_d = 1'b0;
              state_d = S_EMIT;
            end else begin
              state_d = S_RD_L;
            end
          end
        end
      end
      S_RD_L: begin
        mem_re  = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        gsq_d   = gsq_full[stsv_pkg::GSQ_W-1:0];
        state_d = S_RD_R;
      end
      S_RD_R: begin
        sl_d = signed'(mem_rdata);
        if (stereo_q) begin
          mem_re  = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = S_GET_R;
        end else begin
          sr_d    = signed'(mem_rdata);
          state_d = S_SCALE_L;
        end
      end
      S_GET_R: begin
        sr_d    = signed'(mem_rdata);
        state_d = S_SCALE_L;
      end
      S_SCALE_L: begin
        scale_req.valid = 1'b1;
        fin_d   = (cnt_q >= end_q);
        got_l_d = 1'b0;
        state_d = S_SCALE_R;
      end
      S_SCALE_R: begin
        scale_req.valid = 1'b1;
        scale_sample    = sr_q;
        scale_weight    = w_right;
        state_d         = S_WAIT;
      end
      S_WAIT: begin
        // left result comes back first, right one in the cycle after
        if (scale_valid) begin
          if (!got_l_q) begin
            res_l_d = scale_result;
            got_l_d = 1'b1;
          end else begin
            res_r_d = scale_result;
            res_p_d = !fin_q;
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!out_v_q || out_ready_i) begin
          out_v_d = 1'b1;
          out_l_d = res_l_q;
          out_r_d = res_r_q;
          out_p_d = res_p_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      last_q  <= stsv_pkg::LAST_STEP_NONE;
      fin_q   <= 1'b1;
      gsq_q   <= '0;
      sl_q    <= '0;
      sr_q    <= '0;
      got_l_q <= 1'b0;
      res_l_q <= '0;
      res_r_q <= '0;
      res_p_q <= 1'b0;
      out_v_q <= 1'b0;
      out_l_q <= '0;
      out_r_q <= '0;
      out_p_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      fin_q   <= fin_d;
      gsq_q   <= gsq_d;
      sl_q    <= sl_d;
      sr_q    <= sr_d;
      got_l_q <= got_l_d;
      res_l_q <= res_l_d;
      res_r_q <= res_r_d;
      res_p_q <= res_p_d;
      out_v_q <= out_v_d;
      out_l_q <= out_l_d;
      out_r_q <= out_r_d;
      out_p_q <= out_p_d;
    end
  end

  // Writes happen only on accept in idle and reads only in the read states,
  // so the two ports never touch the memory in the same cycle.
  stsv_mem #(
    .DEPTH (SAMPLE_DEPTH),
    .AW    (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'(load_address_i)),
    .wdata_i (load_sample_i),
    .re_i    (mem_re),
    .raddr_i (AddrW'(cnt_q)),
    .rdata_o (mem_rdata)
  );

  stsv_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (scale_req),
    .sample_i  (scale_sample),
    .weight_i  (scale_weight),
    .gain_sq_i (gsq_q),
    .valid_o   (scale_valid),
    .result_o  (scale_result)
  );

  assign out_valid_o = out_v_q;
  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;
  assign playing_o   = out_p_q;

endmodule

`default_nettype wire

@@ design/stsv_checker.sv @@
// ----------------------------------------------------------------------------
// stsv_checker
// Port-level checks on the sample voice, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "step_triggered_sample_voice_unit_assert.svh"

module stsv_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_valid_i,
  input wire logic                                 in_ready_o,
  input wire logic                                 out_valid_o,
  input wire logic                                 out_ready_i,
  input wire logic signed [stsv_pkg::SAMPLE_W-1:0] left_out_o,
  input wire logic signed [stsv_pkg::SAMPLE_W-1:0] right_out_o,
  input wire logic                                 playing_o
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // transactions accepted but whose result is not yet taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  `STSV_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(left_out_o) && $stable(right_out_o) && $stable(playing_o), "result changed while stalled")
  `STSV_ASSERT_NEXT(a_one_in_work, in_acc, !in_ready_o, "input taken while busy")
  `STSV_ASSERT_NOW(a_no_orphan, out_valid_o, pend_q != 2'd0, "result without transaction")
  `STSV_ASSERT_NOW(a_depth, in_ready_o, pend_q < 2'd2, "more than one result waiting")

endmodule

bind step_triggered_sample_voice_unit stsv_checker u_stsv_checker (.*);

`default_nettype wire
